// ----- hw/rtl/cct_pkg.sv -----
package cct_pkg;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // line limit register range and reset
  localparam logic [6:0] LPP_RESET = 7'd61;
  localparam logic [6:0] LPP_MIN   = 7'd10;
  localparam logic [6:0] LPP_MAX   = 7'd100;

  // configuration register indexes
  localparam logic [1:0] REG_LINES_PER_PAGE = 2'd0;
  localparam logic [1:0] REG_EJECT_AT_END   = 2'd1;

  // carriage control skip codes
  typedef enum logic [1:0] {
    SKIP_NONE   = 2'd0,
    SKIP_SINGLE = 2'd1,
    SKIP_DOUBLE = 2'd2,
    SKIP_PAGE   = 2'd3
  } skip_e;

  // converter state carried from byte to byte
  typedef struct packed {
    logic       fortran_mode;
    logic       at_line_start;
    logic       control_pending;
    skip_e      pending_skip;
    logic [6:0] line_count;
    logic [1:0] page_count;
    logic [7:0] char_count;
  } conv_state_t;

  localparam conv_state_t STATE_RESET = '{
    fortran_mode:    1'b1,
    at_line_start:   1'b1,
    control_pending: 1'b0,
    pending_skip:    SKIP_NONE,
    line_count:      7'd0,
    page_count:      2'd0,
    char_count:      8'd0
  };

  // output bytes produced by one input byte, first byte in slot zero
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } result_t;

endpackage

// ----- hw/rtl/cct_core.sv -----
module cct_core #(
  parameter int MAX_LINE = 140
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_input_i,
  input  logic [6:0]           lines_per_page_i,
  input  logic                 eject_at_end_i,
  output cct_pkg::result_t     result_o
);

  localparam logic [7:0] MaxLineB = MAX_LINE[7:0];

  cct_pkg::conv_state_t st_q, st_d;

  logic          do_pag;
  cct_pkg::skip_e skip;
  logic          text;
  logic          endl;
  logic          pag_v, main_v, tail_v;
  logic [7:0]    pag_b, main_b, tail_b;
  logic [6:0]    lim;
  logic [7:0]    nxt;
  logic          page;
  logic [7:0]    cc_base, cc_new;
  logic          is_ctl;
  logic [2:0]    slot_v;
  logic [2:0][7:0] slot_b;
  logic [1:0]    cnt;

  always_comb begin
    // clamp line limit at use
    lim = lines_per_page_i;
    if (lim < cct_pkg::LPP_MIN) lim = cct_pkg::LPP_MIN;
    if (lim > cct_pkg::LPP_MAX) lim = cct_pkg::LPP_MAX;

    st_d    = st_q;
    do_pag  = 1'b0;
    skip    = cct_pkg::SKIP_SINGLE;
    text    = 1'b0;
    endl    = 1'b0;
    main_v  = 1'b0;
    main_b  = in_byte_i;
    tail_v  = 1'b0;
    tail_b  = cct_pkg::CH_NL;
    pag_v   = 1'b0;
    pag_b   = cct_pkg::CH_NL;
    nxt     = 8'd0;
    page    = 1'b0;
    cc_base = st_q.at_line_start ? 8'd0 : st_q.char_count;
    cc_new  = cc_base + 8'd1;
    is_ctl  = (in_byte_i == cct_pkg::CH_ONE) || (in_byte_i == cct_pkg::CH_ZERO) ||
              (in_byte_i == cct_pkg::CH_SPACE) || (in_byte_i == cct_pkg::CH_PLUS);

    // decode the byte against the line position and mode
    if (end_of_input_i) begin
      main_v = !st_q.at_line_start && !st_q.control_pending;
      main_b = cct_pkg::CH_NL;
      tail_v = eject_at_end_i;
      tail_b = cct_pkg::CH_FF;
      st_d   = cct_pkg::STATE_RESET;
    end else if (st_q.at_line_start) begin
      st_d.at_line_start = 1'b0;
      st_d.char_count    = 8'd0;
      if (in_byte_i == cct_pkg::CH_NL) begin
        do_pag = 1'b1;
        main_v = 1'b1;
        main_b = cct_pkg::CH_NL;
        endl   = 1'b1;
      end else if (st_q.fortran_mode && is_ctl) begin
        st_d.control_pending = 1'b1;
        case (in_byte_i)
          cct_pkg::CH_ONE:   st_d.pending_skip = cct_pkg::SKIP_PAGE;
          cct_pkg::CH_ZERO:  st_d.pending_skip = cct_pkg::SKIP_DOUBLE;
          cct_pkg::CH_SPACE: st_d.pending_skip = cct_pkg::SKIP_SINGLE;
          default:           st_d.pending_skip = cct_pkg::SKIP_NONE;
        endcase
      end else begin
        st_d.fortran_mode = 1'b0;
        if (in_byte_i == cct_pkg::CH_FF) begin
          st_d.pending_skip    = cct_pkg::SKIP_PAGE;
          st_d.control_pending = 1'b1;
        end else begin
          st_d.pending_skip    = cct_pkg::SKIP_SINGLE;
          st_d.control_pending = 1'b0;
          do_pag = 1'b1;
          text   = 1'b1;
        end
      end
    end else begin
      do_pag = st_q.control_pending;
      skip   = st_q.pending_skip;
      if (in_byte_i == cct_pkg::CH_NL) begin
        main_v = 1'b1;
        main_b = cct_pkg::CH_NL;
        endl   = 1'b1;
      end else begin
        text = 1'b1;
        st_d.control_pending = 1'b0;
      end
    end

    // text byte, with the split of an overlong line
    if (text) begin
      main_v          = 1'b1;
      main_b          = in_byte_i;
      st_d.char_count = cc_new;
      if (cc_new >= MaxLineB) begin
        tail_v = 1'b1;
        tail_b = cct_pkg::CH_NL;
        endl   = 1'b1;
      end
    end

    if (endl) begin
      st_d.at_line_start   = 1'b1;
      st_d.char_count      = 8'd0;
      st_d.control_pending = 1'b0;
      st_d.pending_skip    = cct_pkg::SKIP_NONE;
    end

    // pagination against the line limit, no form feed before the first page
    if (do_pag) begin
      nxt  = {1'b0, st_q.line_count} + {6'd0, skip};
      page = (st_q.page_count == 2'd0);
      if (!page) begin
        if (skip == cct_pkg::SKIP_PAGE) page = 1'b1;
        else if (nxt > {1'b0, lim}) page = 1'b1;
      end
      if (page) begin
        pag_v = (st_q.page_count != 2'd0);
        pag_b = cct_pkg::CH_FF;
        st_d.page_count = (st_q.page_count == 2'd2) ? 2'd2 : st_q.page_count + 2'd1;
        st_d.line_count = 7'd1;
      end else begin
        pag_v = (skip == cct_pkg::SKIP_DOUBLE);
        pag_b = cct_pkg::CH_NL;
        st_d.line_count = nxt[6:0];
      end
    end
  end

  // pack the produced bytes in order
  assign slot_v = {tail_v, main_v, pag_v};
  assign slot_b = {tail_b, main_b, pag_b};

  always_comb begin
    result_o.bytes = '0;
    cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (slot_v[i]) begin
        result_o.bytes[cnt] = slot_b[i];
        cnt = cnt + 2'd1;
      end
    end
    result_o.cnt = cnt;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cct_pkg::STATE_RESET;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- hw/rtl/cct_serializer.sv -----
module cct_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cct_pkg::result_t result_i,
  output logic             load_ok_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
  output logic             m_axis_tlast   // last
);

  logic [2:0][7:0] buf_q;
  logic [1:0]      left_q, left_d;
  logic [1:0]      pos_q, pos_d;
  logic            xfer;

  assign xfer          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (left_q != 2'd0);
  assign m_axis_tlast  = (left_q == 2'd1);
  assign load_ok_o     = (left_q == 2'd0) || (m_axis_tlast && m_axis_tready);

  // current byte of the held result
  always_comb begin
    case (pos_q)
      2'd0:    m_axis_tdata = buf_q[0];
      2'd1:    m_axis_tdata = buf_q[1];
      2'd2:    m_axis_tdata = buf_q[2];
      default: m_axis_tdata = buf_q[0];
    endcase
  end

  // count down the bytes of the held result
  always_comb begin
    left_d = left_q;
    pos_d  = pos_q;
    if (load_i) begin
      left_d = result_i.cnt;
      pos_d  = 2'd0;
    end else if (xfer) begin
      left_d = left_q - 2'd1;
      pos_d  = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
      pos_q  <= 2'd0;
    end else begin
      left_q <= left_d;
      pos_q  <= pos_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= result_i.bytes;
    end
  end

endmodule

// ----- hw/rtl/carriage_control_to_text.sv -----
// Datapath: an input byte transfer is registered, decoded combinationally from the input
//   register, and its output bytes are loaded into the serializer, which offers them.
// Throughput: one input byte per cycle while each byte yields at most one output byte and
//   the output is not stalled; a byte with output waits for the held result's last byte.
// Reset: rst_ni clears all conversion state and restores lines_per_page 61, eject 0.
module carriage_control_to_text #(
  parameter int MAX_LINE = 140
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  logic       s_axis_tuser,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic       m_axis_tlast,   // last
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  logic             in_v_q;
  logic [7:0]       in_byte_q;
  logic             in_eoi_q;
  logic             advance;
  logic             load;
  logic             load_ok;
  logic [6:0]       lpp_q;
  logic             eject_q;
  cct_pkg::result_t result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpp_q   <= cct_pkg::LPP_RESET;
      eject_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cct_pkg::REG_LINES_PER_PAGE: lpp_q   <= cfg_data_i;
        cct_pkg::REG_EJECT_AT_END:   eject_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a byte with no output passes even while the serializer is busy
  assign advance       = in_v_q && ((result.cnt == 2'd0) || load_ok);
  assign load          = advance && (result.cnt != 2'd0);
  assign s_axis_tready = !in_v_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
  end

  cct_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .in_byte_i        (in_byte_q),
    .end_of_input_i   (in_eoi_q),
    .lines_per_page_i (lpp_q),
    .eject_at_end_i   (eject_q),
    .result_o         (result)
  );

  cct_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .result_i      (result),
    .load_ok_o     (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hw/rtl/cct_checker.sv -----
module cct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic [1:0] run_q;

  // output transfers since the last tlast
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 2'd0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      run_q <= m_axis_tlast ? 2'd0 : run_q + 2'd1;
    end
  end

  // a stalled output transfer stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled output keeps its byte and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // one input byte yields at most three output bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (run_q == 2'd2) |-> m_axis_tlast)
    else $error("more than three output bytes in one run");

  // an idle output starts offering only after a preceding input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output offered without a preceding input transfer");

endmodule

bind carriage_control_to_text cct_checker u_cct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
